// ===== hdl/blm_pkg.sv =====
package blm_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVIDER  = 3'd0,
        CFG_EMPTY    = 3'd1,
        CFG_FULL     = 3'd2,
        CFG_THRESH   = 3'd3,
        CFG_INTERVAL = 3'd4
    } t_cfg_reg;

    localparam logic [11:0] RST_DIVIDER  = 12'd512;
    localparam logic [15:0] RST_EMPTY    = 16'd3300;
    localparam logic [15:0] RST_FULL     = 16'd4200;
    localparam logic [6:0]  RST_THRESH   = 7'd15;
    localparam logic [31:0] RST_INTERVAL = 32'd10000;

    localparam logic [6:0]  PCT_FULL_SCALE = 7'd100;
    localparam logic [7:0]  HYSTERESIS_PCT = 8'd5;
    localparam logic signed [7:0] PCT_UNKNOWN = -8'sd1;

    localparam logic OP_STARTUP = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // quotient bits produced by the serial divider
    localparam int unsigned QUO_W = 7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TIME,
        S_TCMP,
        S_SPAN,
        S_MUL,
        S_EMPTY,
        S_SCALE,
        S_OVF,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [31:0] now_ms;
        logic [11:0] adc_millivolts;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0] percent;
        logic              battery_low;
        logic              low_event;
        logic              sampled;
    } t_out_item;

endpackage

// ===== hdl/blm_in_if.sv =====
interface blm_in_if;
    import blm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/blm_out_if.sv =====
interface blm_out_if;
    import blm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/blm_cfg_if.sv =====
interface blm_cfg_if;
    import blm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hdl/battery_level_monitor_unit.sv =====
// channel  | dir | payload                                    | handshake
// i_in     | in  | operation, now_ms, adc_millivolts          | valid/ready
// o_out    | out | percent, battery_low, low_event, sampled   | valid/ready
// i_cfg    | in  | index (3 bits), wdata (32 bits)            | valid/ready, ready always high
//
// an item steps through the states from acceptance to the result register; an update that
// comes before the interval is up goes from the time compare straight to the finish step,
// and a forced zero or a saturating quotient skips the 7 steps of the serial divider
// compares and division share one 32-bit subtractor; a small multiplier scales the reading
// input ready is high only in the idle state; a result waits in the output register
// while the next item is accepted, and the finish step stalls if it is still full
// reset (synchronous, active low) restores the register defaults and percent -1
module battery_level_monitor_unit
    import blm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    blm_in_if.sink    i_in,
    blm_out_if.source o_out,
    blm_cfg_if.sink   i_cfg
);

    t_state r_state, n_state;

    // configuration
    logic [11:0] r_cfg_div;
    logic [15:0] r_cfg_empty;
    logic [15:0] r_cfg_full;
    logic [6:0]  r_cfg_thresh;
    logic [31:0] r_cfg_interval;

    // monitor state
    logic [31:0]       r_last, n_last;
    logic signed [7:0] r_pct, n_pct;
    logic              r_low, n_low;
    logic              r_sent, n_sent;

    // item and working registers
    logic              r_op;
    logic [31:0]       r_now;
    logic [11:0]       r_adc;
    logic [31:0]       r_acc, n_acc;
    logic [15:0]       r_span, n_span;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_take, n_take;
    logic              r_zero, n_zero;

    // output register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // shared subtractor
    logic [31:0] alu_a, alu_b, alu_diff;
    logic        alu_borrow;
    logic [23:0] product;
    logic        out_free;
    logic [6:0]  pct_new;
    logic        accept;

    assign {alu_borrow, alu_diff} = {1'b0, alu_a} - {1'b0, alu_b};
    assign product  = {12'd0, r_adc} * {12'd0, r_cfg_div};
    assign out_free = !r_out_valid || o_out.ready;
    assign pct_new  = (r_quo > PCT_FULL_SCALE) ? PCT_FULL_SCALE : r_quo;
    assign accept   = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign i_cfg.ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_TIME;
            S_TIME:  n_state = S_TCMP;
            S_TCMP:  n_state = (r_op == OP_UPDATE && alu_borrow) ? S_FIN : S_SPAN;
            S_SPAN:  n_state = S_MUL;
            S_MUL:   n_state = S_EMPTY;
            S_EMPTY: n_state = S_SCALE;
            S_SCALE: n_state = r_zero ? S_FIN : S_OVF;
            S_OVF:   n_state = alu_borrow ? S_DIV : S_FIN;
            S_DIV:   if (r_cnt == 3'd0) n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        i_in.ready  = 1'b0;
        alu_a       = r_acc;
        alu_b       = 32'd0;
        n_acc       = r_acc;
        n_span      = r_span;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_take      = r_take;
        n_zero      = r_zero;
        n_last      = r_last;
        n_pct       = r_pct;
        n_low       = r_low;
        n_sent      = r_sent;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                n_zero     = 1'b0;
            end
            S_TIME: begin
                alu_a = r_now;
                alu_b = r_last;
                n_acc = alu_diff;
            end
            S_TCMP: begin
                alu_b  = r_cfg_interval;
                n_take = (r_op == OP_STARTUP) || !alu_borrow;
            end
            S_SPAN: begin
                alu_a  = {16'd0, r_cfg_full};
                alu_b  = {16'd0, r_cfg_empty};
                n_span = alu_diff[15:0];
                // full not above empty forces zero percent
                n_zero = alu_borrow || (alu_diff == 32'd0);
            end
            S_MUL: begin
                n_acc = {16'd0, product[23:8]};
            end
            S_EMPTY: begin
                alu_b  = {16'd0, r_cfg_empty};
                n_acc  = alu_diff;
                n_zero = r_zero || alu_borrow || (alu_diff == 32'd0);
            end
            S_SCALE: begin
                // times 100 as 64 + 32 + 4
                n_acc = (r_acc << 6) + (r_acc << 5) + (r_acc << 2);
                n_quo = '0;
            end
            S_OVF: begin
                // quotient of 128 or more saturates at once
                alu_b = {9'd0, r_span, 7'd0};
                n_quo = alu_borrow ? '0 : PCT_FULL_SCALE;
                n_cnt = 3'(QUO_W - 1);
            end
            S_DIV: begin
                alu_b = {16'd0, r_span} << r_cnt;
                if (!alu_borrow) n_acc = alu_diff;
                n_quo = {r_quo[QUO_W-2:0], !alu_borrow};
                n_cnt = r_cnt - 3'd1;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.low_event = 1'b0;
                    n_out.sampled   = r_take;
                    if (r_take) begin
                        n_pct = signed'({1'b0, pct_new});
                    end
                    if (r_take && r_op == OP_UPDATE) begin
                        n_last = r_now;
                        if (pct_new <= r_cfg_thresh) begin
                            n_low = 1'b1;
                            if (!r_sent) begin
                                n_sent          = 1'b1;
                                n_out.low_event = 1'b1;
                            end
                        end else if ({1'b0, pct_new} > ({1'b0, r_cfg_thresh} + HYSTERESIS_PCT)) begin
                            n_low  = 1'b0;
                            n_sent = 1'b0;
                        end
                    end
                    n_out.percent     = r_take ? signed'({1'b0, pct_new}) : r_pct;
                    n_out.battery_low = n_low;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cfg_div      <= RST_DIVIDER;
            r_cfg_empty    <= RST_EMPTY;
            r_cfg_full     <= RST_FULL;
            r_cfg_thresh   <= RST_THRESH;
            r_cfg_interval <= RST_INTERVAL;
            r_last         <= '0;
            r_pct          <= PCT_UNKNOWN;
            r_low          <= 1'b0;
            r_sent         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_pct       <= n_pct;
            r_low       <= n_low;
            r_sent      <= n_sent;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_DIVIDER:  r_cfg_div      <= i_cfg.wdata[11:0];
                    CFG_EMPTY:    r_cfg_empty    <= i_cfg.wdata[15:0];
                    CFG_FULL:     r_cfg_full     <= i_cfg.wdata[15:0];
                    CFG_THRESH:   r_cfg_thresh   <= i_cfg.wdata[6:0];
                    CFG_INTERVAL: r_cfg_interval <= i_cfg.wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_in.data.operation;
            r_now <= i_in.data.now_ms;
            r_adc <= i_in.data.adc_millivolts;
        end
        r_acc  <= n_acc;
        r_span <= n_span;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_take <= n_take;
        r_zero <= n_zero;
        r_out  <= n_out;
    end

    // low flag and event latch always move together
    a_low_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low == r_sent)
        else $error("low flag and event latch disagree");

    a_event_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.low_event) |-> r_out.battery_low)
        else $error("low event without low state");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_TIME))
        else $error("accepted transaction did not start the sequence");

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= 3'(QUO_W - 1)))
        else $error("divider step count out of range");

    a_zero_quo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_take && r_zero) |-> (r_quo == '0))
        else $error("forced zero percent lost");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import blm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 60;

    logic i_clk;
    logic i_rst_n;

    blm_in_if  in_if();
    blm_out_if out_if();
    blm_cfg_if cfg_if();

    battery_level_monitor_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // register copies
    logic [11:0] cfg_div;
    logic [15:0] cfg_empty;
    logic [15:0] cfg_full;
    logic [6:0]  cfg_thresh;
    logic [31:0] cfg_interval;

    // monitor state
    logic [31:0]       sample_ms_q;
    logic signed [7:0] pct_q;
    logic              low_q;
    logic              low_reported_q;

    t_out_item expected_readings[$];
    int        fault_cnt;
    int        reading_cnt;
    bit        quiet;
    bit        hold_ask;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver side: random stalls plus one long hold-off on request
    initial begin : result_ready_gen
        int held;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_ask) begin
                hold_ask = 1'b0;
                held = HOLD_CYCLES;
            end
            if (held > 0) begin
                held--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= quiet || ($urandom_range(99) >= 7);
            end
        end
    end

    function automatic logic [7:0] charge_pct(input logic [11:0] adc);
        logic [23:0] scaled;
        logic [31:0] above;
        logic [31:0] span;
        logic [31:0] q;
        scaled = adc * cfg_div;
        if (cfg_full <= cfg_empty || scaled[23:8] <= cfg_empty) return '0;
        above = scaled[23:8] - cfg_empty;
        span  = cfg_full - cfg_empty;
        q = (above * PCT_FULL_SCALE) / span;
        if (q > PCT_FULL_SCALE) q = PCT_FULL_SCALE;
        return q[7:0];
    endfunction

    function automatic t_out_item predict_reading(input t_in_item it);
        t_out_item   r;
        logic [7:0]  p;
        logic [31:0] elapsed;
        r = '0;
        elapsed = it.now_ms - sample_ms_q;
        if (it.operation == OP_STARTUP) begin
            pct_q = charge_pct(it.adc_millivolts);
            r.sampled = 1'b1;
        end else if (elapsed >= cfg_interval) begin
            sample_ms_q = it.now_ms;
            p = charge_pct(it.adc_millivolts);
            pct_q = p;
            r.sampled = 1'b1;
            if (p <= cfg_thresh) begin
                low_q = 1'b1;
                if (!low_reported_q) begin
                    low_reported_q = 1'b1;
                    r.low_event = 1'b1;
                end
            end else if (int'(p) > int'(cfg_thresh) + int'(HYSTERESIS_PCT)) begin
                low_q = 1'b0;
                low_reported_q = 1'b0;
            end
        end
        r.percent = pct_q;
        r.battery_low = low_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            reading_cnt++;
            if (expected_readings.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= REPORT_LIMIT)
                    $display("reading %0d: unexpected result pct %0d low %b evt %b smp %b",
                             reading_cnt, out_if.data.percent, out_if.data.battery_low,
                             out_if.data.low_event, out_if.data.sampled);
            end else begin
                want = expected_readings.pop_front();
                if (out_if.data.percent !== want.percent
                        || out_if.data.battery_low !== want.battery_low
                        || out_if.data.low_event !== want.low_event
                        || out_if.data.sampled !== want.sampled) begin
                    fault_cnt++;
                    if (fault_cnt <= REPORT_LIMIT)
                        $display({"reading %0d: expected pct %0d low %b evt %b smp %b,",
                                  " got pct %0d low %b evt %b smp %b"},
                                 reading_cnt, want.percent, want.battery_low, want.low_event,
                                 want.sampled, out_if.data.percent, out_if.data.battery_low,
                                 out_if.data.low_event, out_if.data.sampled);
                end
            end
        end
    end

    // valid is left high after a transaction so back-to-back items keep it steady
    task automatic send_reading(input logic op, input logic [31:0] now, input logic [11:0] adc);
        t_in_item it;
        it.operation      = op;
        it.now_ms         = now;
        it.adc_millivolts = adc;
        if (!quiet) begin
            while ($urandom_range(99) < 7) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        expected_readings.push_back(predict_reading(it));
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // unused bits above each register get random junk
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        logic [31:0] junk;
        junk = $urandom;
        case (idx)
            CFG_DIVIDER: begin
                val = {junk[31:12], val[11:0]};
                cfg_div = val[11:0];
            end
            CFG_EMPTY: begin
                val = {junk[31:16], val[15:0]};
                cfg_empty = val[15:0];
            end
            CFG_FULL: begin
                val = {junk[31:16], val[15:0]};
                cfg_full = val[15:0];
            end
            CFG_THRESH: begin
                val = {junk[31:7], val[6:0]};
                cfg_thresh = val[6:0];
            end
            CFG_INTERVAL: cfg_interval = val;
            default: ;
        endcase
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    task automatic set_config(input logic [11:0] div, input logic [15:0] empty_mv,
                              input logic [15:0] full_mv, input logic [6:0] thresh,
                              input logic [31:0] interval);
        write_reg(CFG_DIVIDER, 32'(div));
        write_reg(CFG_EMPTY, 32'(empty_mv));
        write_reg(CFG_FULL, 32'(full_mv));
        write_reg(CFG_THRESH, 32'(thresh));
        write_reg(CFG_INTERVAL, interval);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // reset defaults: interval gating, start-up read, entry and exit of low
    task automatic test_startup_and_hysteresis();
        send_reading(OP_UPDATE, 32'd5, 12'd2000);
        send_reading(OP_STARTUP, 32'd0, 12'd2000);
        send_reading(OP_UPDATE, 32'd10000, 12'd1650);
        send_reading(OP_UPDATE, 32'd20000, 12'd1650);
        send_reading(OP_UPDATE, 32'd30000, 12'd1900);
        send_reading(OP_UPDATE, 32'd40000, 12'd4095);
        send_reading(OP_UPDATE, 32'd40001, 12'd0);
        send_reading(OP_STARTUP, 32'd40002, 12'd0);
    endtask

    task automatic test_config_corners();
        wait_idle();
        // unity divider and 0..100 mV span: percent equals adc up to 100
        set_config(12'd256, 16'd0, 16'd100, 7'd20, 32'd0);
        for (int k = int'(CFG_INTERVAL) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(k[CFG_IDX_W-1:0], $urandom);
        cfg_if.valid <= 1'b0;
        send_reading(OP_UPDATE, 32'd100, 12'd21);
        send_reading(OP_UPDATE, 32'd100, 12'd20);
        send_reading(OP_UPDATE, 32'd101, 12'd25);
        send_reading(OP_UPDATE, 32'd102, 12'd26);
        send_reading(OP_UPDATE, 32'd103, 12'd0);
        send_reading(OP_UPDATE, 32'd104, 12'd100);

        // threshold above full scale keeps low set
        wait_idle();
        set_config(12'd256, 16'd0, 16'd100, 7'd127, 32'd0);
        send_reading(OP_UPDATE, 32'd105, 12'd4095);

        wait_idle();
        set_config(12'd0, 16'd0, 16'd100, 7'd20, 32'd0);
        send_reading(OP_UPDATE, 32'hFFFF_FFFF, 12'd4095);

        wait_idle();
        set_config(12'd4095, 16'd0, 16'd65535, 7'd100, 32'd0);
        send_reading(OP_UPDATE, 32'h8000_0000, 12'd4095);
        send_reading(OP_STARTUP, 32'h8000_0000, 12'hAAA);

        // full not above empty
        wait_idle();
        set_config(12'd512, 16'd3000, 16'd3000, 7'd15, 32'd0);
        send_reading(OP_STARTUP, 32'd0, 12'd4000);
        wait_idle();
        set_config(12'd512, 16'd65535, 16'd0, 7'd15, 32'd0);
        send_reading(OP_UPDATE, 32'd1, 12'h555);

        // largest interval, then timestamp wrap with a short interval
        wait_idle();
        set_config(12'd512, 16'd3300, 16'd4200, 7'd15, 32'hFFFF_FFFF);
        send_reading(OP_UPDATE, sample_ms_q - 32'd1, 12'd2100);
        send_reading(OP_UPDATE, sample_ms_q, 12'd2100);
        wait_idle();
        set_config(12'd512, 16'd3300, 16'd4200, 7'd15, 32'd100);
        send_reading(OP_UPDATE, 32'hFFFF_FFF0, 12'd1800);
        send_reading(OP_UPDATE, 32'd20, 12'd1800);
        send_reading(OP_UPDATE, 32'd200, 12'd2000);
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        logic [31:0] now;
        wait_idle();
        set_config(12'd256, 16'd0, 16'd100, 7'd20, 32'd0);
        hold_ask = 1'b1;
        now = sample_ms_q;
        for (int n = 0; n < 12; n++) begin
            now = now + 32'd1;
            send_reading(OP_UPDATE, now, 12'($urandom_range(0, 120)));
        end
    endtask

    function automatic logic [11:0] adc_for_level();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] tgt;
        logic [31:0] a;
        if (cfg_div == 0 || $urandom_range(99) < 30) return 12'($urandom);
        lo  = (cfg_empty > 200) ? 32'(cfg_empty) - 32'd200 : 32'd0;
        hi  = 32'(cfg_full) + 32'd200;
        tgt = $urandom_range(lo, hi);
        a   = (tgt * 256 + 32'(cfg_div) - 1) / 32'(cfg_div);
        return (a > 32'd4095) ? 12'd4095 : a[11:0];
    endfunction

    task automatic test_random_readings();
        logic [31:0] now;
        logic [15:0] e;
        int          r;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_idle();
            quiet = (ph == 3);
            e = 16'($urandom_range(0, 8000));
            case (ph)
                5: set_config(12'($urandom_range(256, 2048)), e,
                              16'(e - $urandom_range(0, 500)),
                              7'($urandom_range(0, 100)), $urandom_range(0, 20));
                6: set_config(12'd4095, 16'd0, 16'd65535, 7'd100, 32'd0);
                7: set_config(12'd1, 16'd0, 16'd1, 7'd0, 32'd1);
                default: set_config(12'($urandom_range(256, 2048)), e,
                                    16'(e + $urandom_range(1, 4000)),
                                    7'($urandom_range(0, 100)),
                                    ($urandom_range(9) == 0) ? $urandom
                                                             : $urandom_range(0, 50));
            endcase
            now = sample_ms_q;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(99);
                if (r < 10)
                    now = now + $urandom;
                else if (r < 55)
                    now = sample_ms_q + cfg_interval + $urandom_range(0, 2);
                else if (r < 75)
                    now = sample_ms_q + cfg_interval - 32'd1;
                else
                    now = now + $urandom_range(0, 20);
                send_reading(($urandom_range(99) < 12) ? OP_STARTUP : OP_UPDATE,
                             now, adc_for_level());
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.wdata = '0;
        quiet        = 1'b0;
        hold_ask     = 1'b0;
        fault_cnt    = 0;
        reading_cnt  = 0;

        cfg_div        = RST_DIVIDER;
        cfg_empty      = RST_EMPTY;
        cfg_full       = RST_FULL;
        cfg_thresh     = RST_THRESH;
        cfg_interval   = RST_INTERVAL;
        sample_ms_q    = '0;
        pct_q          = PCT_UNKNOWN;
        low_q          = 1'b0;
        low_reported_q = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_startup_and_hysteresis();
        test_config_corners();
        test_output_backpressure();
        test_random_readings();

        wait_idle();
        if (fault_cnt == 0 && expected_readings.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
